>>> src/kss_pkg.sv
// kss_pkg: shared widths, configuration register indexes and the cell link types
// for the k-slot list scheduler. No dependencies.
`timescale 1ns / 1ps

package kss_pkg;

    localparam int TIME_W       = 32;
    localparam int DUR_W        = 16;
    localparam int SLOT_CNT_W   = 7;
    localparam int MAX_SLOTS_DEF = 64;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE   = 1'b1;

    typedef struct packed {
        logic              clear;
        logic              insert;
        logic              replace;
        logic [TIME_W-1:0] value;
    } kss_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] val;
        logic              valid;
        logic              gt;
    } kss_link_t;

endpackage

>>> src/kss_cell.sv
// kss_cell: one slot of the sorted finish-time chain; on insert or replace it takes
// the new value or a neighbor's (left on insert, right on replace). Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_cell
    import kss_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  kss_cmd_t  cmd,
    input  kss_link_t left,
    input  kss_link_t right,
    output kss_link_t link
);

    logic [TIME_W-1:0] val_reg;
    logic [TIME_W-1:0] val_next;
    logic              valid_reg;
    logic              valid_next;
    logic              gt_self;
    logic              hold_self;

    assign gt_self   = !valid_reg || (val_reg > cmd.value);
    assign hold_self = IS_HEAD ? 1'b0 : gt_self;
    assign link      = '{val: val_reg, valid: valid_reg, gt: gt_self};

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        priority if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.insert)
        begin
            if (left.gt)
            begin
                val_next   = left.val;
                valid_next = left.valid;
            end
            else if (gt_self)
            begin
                val_next   = cmd.value;
                valid_next = 1'b1;
            end
        end
        else if (cmd.replace)
        begin
            if (!hold_self)
            begin
                if (right.gt)
                begin
                    val_next   = cmd.value;
                    valid_next = 1'b1;
                end
                else
                begin
                    val_next   = right.val;
                    valid_next = right.valid;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

>>> src/k_slot_list_scheduler_unit.sv
// k_slot_list_scheduler_unit: top level of the k-slot greedy list scheduler.
// Depends on kss_pkg and kss_cell.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis: one job per beat. tdata = job_duration, tuser = start_run, tlast = last_job.
//   m_axis: one result per job. tdata = finish_time, tuser = {run_failed, job_late},
//   tlast = run_done.
//   cfg: register writes (index 0 slot_count, index 1 deadline), always ready; write
//   only while no job is in flight.
//   Latency: the result is valid the cycle after the input beat is accepted.
//   Pacing: the accept cycle reads the head of the cell chain and forms the finish
//   time; for a stored job, pend_cmd_reg then shifts the chain to insert it while
//   pend_reg holds s_axis_tready low. A late job, or one after the run has failed,
//   leaves the chain alone, so the next job can follow in the next cycle. A new job
//   is taken once any shift is done and the output register is free or being drained.
//   Reset: all slots empty, failed flag clear, slot_count 1, deadline 0; no clearing
//   pass is needed.
//   Stall: a result held in the output register blocks s_axis_tready until taken.

module k_slot_list_scheduler_unit
    import kss_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DUR_W-1:0]      s_axis_tdata,   // [15:0] job_duration
    input  logic                  s_axis_tuser,   // [0] start_run
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TIME_W-1:0]     m_axis_tdata,   // [31:0] finish_time
    output logic [1:0]            m_axis_tuser,   // [0] job_late, [1] run_failed
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int KW = (CW > SLOT_CNT_W) ? CW : SLOT_CNT_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_SLOTS);

    logic [SLOT_CNT_W-1:0] slot_count_reg;
    logic [TIME_W-1:0]     deadline_reg;
    logic [CW-1:0]         busy_reg;
    logic                  failed_reg;
    logic                  pend_reg;
    kss_cmd_t              pend_cmd_reg;
    logic                  out_valid_reg;
    logic [TIME_W-1:0]     out_fin_reg;
    logic                  out_late_reg;
    logic                  out_failed_reg;
    logic                  out_done_reg;

    kss_link_t             links [MAX_SLOTS];
    kss_link_t             lefts [MAX_SLOTS];
    kss_link_t             rights [MAX_SLOTS];
    kss_cmd_t              cmd;

    logic                  accept;
    logic                  start;
    logic [KW-1:0]         k_eff;
    logic [KW-1:0]         busy_eff;
    logic                  failed_eff;
    logic                  replace;
    logic [TIME_W-1:0]     begin_time;
    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     fin;
    logic                  late;
    logic                  store;
    logic                  grow;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !pend_reg && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tuser;

    always_comb
    begin
        priority if (slot_count_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (KW'(slot_count_reg) > MAX_K)
        begin
            k_eff = MAX_K;
        end
        else
        begin
            k_eff = KW'(slot_count_reg);
        end
    end

    assign busy_eff   = start ? '0 : KW'(busy_reg);
    assign failed_eff = start ? 1'b0 : failed_reg;
    assign replace    = (busy_eff >= k_eff) && (busy_eff != '0);
    assign begin_time = replace ? links[0].val : '0;
    assign sum        = {1'b0, begin_time} + {{(TIME_W + 1 - DUR_W){1'b0}}, s_axis_tdata};
    assign fin        = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    assign late       = fin > deadline_reg;
    assign store      = !failed_eff && !late && (replace || (busy_eff < MAX_K));
    assign grow       = store && !replace;

    always_comb
    begin
        cmd = pend_cmd_reg;
        if (!pend_reg)
        begin
            cmd.insert  = 1'b0;
            cmd.replace = 1'b0;
        end
        cmd.clear = accept && start;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLOTS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_left_edge
                assign lefts[gi] = '{val: '0, valid: 1'b1, gt: 1'b0};
            end
            else
            begin : g_left
                assign lefts[gi] = links[gi-1];
            end
            if (gi == MAX_SLOTS - 1)
            begin : g_right_edge
                assign rights[gi] = '{val: '0, valid: 1'b0, gt: 1'b1};
            end
            else
            begin : g_right
                assign rights[gi] = links[gi+1];
            end
            kss_cell #(
                .IS_HEAD (gi == 0)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (lefts[gi]),
                .right (rights[gi]),
                .link  (links[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_CNT_W'(1);
            deadline_reg   <= '0;
            busy_reg       <= '0;
            failed_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SLOT_COUNT: slot_count_reg <= cfg_data[SLOT_CNT_W-1:0];
                    CFG_DEADLINE:   deadline_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            if (accept)
            begin
                busy_reg   <= grow ? CW'(busy_eff + KW'(1)) : CW'(busy_eff);
                failed_reg <= failed_eff || late;
                pend_reg   <= store;
            end
            else
            begin
                pend_reg <= 1'b0;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_cmd_reg.clear   <= 1'b0;
            pend_cmd_reg.insert  <= grow;
            pend_cmd_reg.replace <= store && replace;
            pend_cmd_reg.value   <= fin;
            out_fin_reg          <= fin;
            out_late_reg         <= late;
            out_failed_reg       <= failed_eff || late;
            out_done_reg         <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_fin_reg;
    assign m_axis_tuser  = {out_failed_reg, out_late_reg};
    assign m_axis_tlast  = out_done_reg;

endmodule

>>> src/kss_checker.sv
// kss_checker: port-level assertions for k_slot_list_scheduler_unit, bound to it.
// Depends on kss_pkg and the top level.
`timescale 1ns / 1ps

module kss_checker
    import kss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [DUR_W-1:0]      s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [TIME_W-1:0]     m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    logic s_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_late_fails: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tuser[0] || m_axis_tuser[1])
        else $error("late job without failed run");

    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> m_axis_tvalid && (m_axis_tdata >= TIME_W'($past(s_axis_tdata)))
            && (m_axis_tlast == $past(s_axis_tlast)))
        else $error("result does not follow its job");

    a_fresh_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && s_axis_tuser |=> m_axis_tuser[1] == m_axis_tuser[0])
        else $error("failed flag not cleared at run start");

endmodule

bind k_slot_list_scheduler_unit kss_checker u_kss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
